@@ rtl/bhg_pkg.sv @@
// Shared types and constants of the Bezier handle generator.
`default_nettype none
package bhg_pkg;

   localparam int COORD_W      = 32;
   localparam int DIFF_W       = 33;
   localparam int RAD_W        = 66;
   localparam int ROOT_W       = 33;
   localparam int REM_W        = 36;
   localparam int RATIO_BITS   = 16;
   localparam int SQRT_STEPS   = 33;
   localparam int FRONT_STAGES = 3;
   localparam int BACK_STAGES  = 2;

   localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd21845;

   typedef enum logic {
      OP_QUAD   = 1'b0,
      OP_TRIPLE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     opcode;
      logic signed [COORD_W-1:0]  p1_x;
      logic signed [COORD_W-1:0]  p1_y;
      logic signed [COORD_W-1:0]  p2_x;
      logic signed [COORD_W-1:0]  p2_y;
      logic signed [COORD_W-1:0]  p3_x;
      logic signed [COORD_W-1:0]  p3_y;
      logic signed [COORD_W-1:0]  p4_x;
      logic signed [COORD_W-1:0]  p4_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  h1_x;
      logic signed [COORD_W-1:0]  h1_y;
      logic signed [COORD_W-1:0]  h2_x;
      logic signed [COORD_W-1:0]  h2_y;
      logic                       degenerate;
   } rsp_type;

   typedef struct packed {
      op_type                     op;
      logic signed [COORD_W-1:0]  a1_x;
      logic signed [COORD_W-1:0]  a1_y;
      logic signed [COORD_W-1:0]  a2_x;
      logic signed [COORD_W-1:0]  a2_y;
      logic [DIFF_W-1:0]          d1x_mag;
      logic [DIFF_W-1:0]          d1y_mag;
      logic [DIFF_W-1:0]          d2x_mag;
      logic [DIFF_W-1:0]          d2y_mag;
      logic                       d1x_neg;
      logic                       d1y_neg;
      logic                       d2x_neg;
      logic                       d2y_neg;
      logic [DIFF_W-1:0]          off_x_mag;
      logic [DIFF_W-1:0]          off_y_mag;
      logic                       off_x_neg;
      logic                       off_y_neg;
   } side_type;

   typedef struct packed {
      side_type                   side;
      logic [ROOT_W-1:0]          s;
      logic                       z1;
      logic                       z2;
   } mid_type;

endpackage
`default_nettype wire

@@ rtl/bhg_front.sv @@
// Front stages: differences, squares and squared lengths of the three vectors.
`default_nettype none
module bhg_front (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire bhg_pkg::req_type                  req,
   input  wire logic [bhg_pkg::RATIO_BITS-1:0]    ratio,
   output logic [bhg_pkg::RAD_W-1:0]              rad1,
   output logic [bhg_pkg::RAD_W-1:0]              rad2,
   output logic [bhg_pkg::RAD_W-1:0]              rad3,
   output bhg_pkg::side_type                      side
);

   localparam int DW = bhg_pkg::DIFF_W;
   localparam int RW = bhg_pkg::RAD_W;
   localparam int QB = bhg_pkg::RATIO_BITS;
   localparam int OW = DW + QB;

   function automatic logic [DW:0] abs_diff(input logic [DW-2:0] a, input logic [DW-2:0] b);
      logic [DW-1:0] d;
      d = {a[DW-2], a} - {b[DW-2], b};
      return {d[DW-1], (d[DW-1] ? ({DW{1'b0}} - d) : d)};
   endfunction

   function automatic logic [RW-1:0] square(input logic [DW-1:0] m);
      return {{(RW-DW){1'b0}}, m} * {{(RW-DW){1'b0}}, m};
   endfunction

   bhg_pkg::side_type s1_in, s1_ff, s2_in, s2_ff, s3_ff;
   logic [DW:0]   d3x_in, d3y_in, d3x_ff, d3y_ff;
   logic [DW:0]   d1x, d1y, d2x, d2y;
   logic          quad;
   logic [OW-1:0] offx, offy;
   logic [RW-1:0] sq1x_ff, sq1y_ff, sq2x_ff, sq2y_ff, sq3x_ff, sq3y_ff;
   logic [RW-1:0] rad1_ff, rad2_ff, rad3_ff;

   always_comb begin
      quad = (req.opcode == bhg_pkg::OP_QUAD);
      d1x  = abs_diff(req.p3_x, req.p1_x);
      d1y  = abs_diff(req.p3_y, req.p1_y);
      d2x  = abs_diff(req.p4_x, req.p2_x);
      d2y  = abs_diff(req.p4_y, req.p2_y);
      d3x_in = quad ? abs_diff(req.p3_x, req.p2_x) : abs_diff(req.p2_x, req.p1_x);
      d3y_in = quad ? abs_diff(req.p3_y, req.p2_y) : abs_diff(req.p2_y, req.p1_y);
      s1_in.op        = req.opcode;
      s1_in.a1_x      = quad ? req.p2_x : req.p1_x;
      s1_in.a1_y      = quad ? req.p2_y : req.p1_y;
      s1_in.a2_x      = quad ? req.p3_x : req.p2_x;
      s1_in.a2_y      = quad ? req.p3_y : req.p2_y;
      s1_in.d1x_mag   = d1x[DW-1:0];
      s1_in.d1y_mag   = d1y[DW-1:0];
      s1_in.d2x_mag   = d2x[DW-1:0];
      s1_in.d2y_mag   = d2y[DW-1:0];
      s1_in.d1x_neg   = d1x[DW];
      s1_in.d1y_neg   = d1y[DW];
      s1_in.d2x_neg   = d2x[DW];
      s1_in.d2y_neg   = d2y[DW];
      s1_in.off_x_mag = '0;
      s1_in.off_y_mag = '0;
      s1_in.off_x_neg = 1'b0;
      s1_in.off_y_neg = 1'b0;
   end

   always_comb begin
      offx  = {{QB{1'b0}}, d3x_ff[DW-1:0]} * {{DW{1'b0}}, ratio};
      offy  = {{QB{1'b0}}, d3y_ff[DW-1:0]} * {{DW{1'b0}}, ratio};
      s2_in = s1_ff;
      s2_in.off_x_mag = offx[OW-1:QB];
      s2_in.off_y_mag = offy[OW-1:QB];
      s2_in.off_x_neg = d3x_ff[DW];
      s2_in.off_y_neg = d3y_ff[DW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= s1_in;
         d3x_ff  <= d3x_in;
         d3y_ff  <= d3y_in;
         s2_ff   <= s2_in;
         sq1x_ff <= square(s1_ff.d1x_mag);
         sq1y_ff <= square(s1_ff.d1y_mag);
         sq2x_ff <= square(s1_ff.d2x_mag);
         sq2y_ff <= square(s1_ff.d2y_mag);
         sq3x_ff <= square(d3x_ff[DW-1:0]);
         sq3y_ff <= square(d3y_ff[DW-1:0]);
         s3_ff   <= s2_ff;
         rad1_ff <= sq1x_ff + sq1y_ff;
         rad2_ff <= sq2x_ff + sq2y_ff;
         rad3_ff <= sq3x_ff + sq3y_ff;
      end
   end

   assign rad1 = rad1_ff;
   assign rad2 = rad2_ff;
   assign rad3 = rad3_ff;
   assign side = s3_ff;

endmodule
`default_nettype wire

@@ rtl/bhg_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module bhg_sqrt_pipe (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [bhg_pkg::RAD_W-1:0]    radicand,
   output logic [bhg_pkg::ROOT_W-1:0]        root
);

   localparam int N  = bhg_pkg::SQRT_STEPS;
   localparam int RW = bhg_pkg::RAD_W;
   localparam int QW = bhg_pkg::ROOT_W;
   localparam int EW = bhg_pkg::REM_W;

   logic [RW-1:0] rad_src [N];
   logic [EW-1:0] rem_src [N];
   logic [QW-1:0] root_src[N];
   logic [RW-1:0] rad_in  [N];
   logic [EW-1:0] rem_in  [N];
   logic [QW-1:0] root_in [N];
   logic [RW-1:0] rad_ff  [N];
   logic [EW-1:0] rem_ff  [N];
   logic [QW-1:0] root_ff [N];

   always_comb begin
      logic [EW-1:0] sh;
      logic [EW-1:0] tr;
      rad_src[0]  = radicand;
      rem_src[0]  = '0;
      root_src[0] = '0;
      for (int i = 1; i < N; i++) begin
         rad_src[i]  = rad_ff[i-1];
         rem_src[i]  = rem_ff[i-1];
         root_src[i] = root_ff[i-1];
      end
      for (int i = 0; i < N; i++) begin
         sh = {rem_src[i][EW-3:0], rad_src[i][RW-1:RW-2]};
         tr = {1'b0, root_src[i], 2'b01};
         rad_in[i] = {rad_src[i][RW-3:0], 2'b00};
         if (sh >= tr) begin
            rem_in[i]  = sh - tr;
            root_in[i] = {root_src[i][QW-2:0], 1'b1};
         end else begin
            rem_in[i]  = sh;
            root_in[i] = {root_src[i][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            rad_ff[i]  <= rad_in[i];
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
         end
      end
   end

   assign root = root_ff[N-1];

endmodule
`default_nettype wire

@@ rtl/bhg_div_pipe.sv @@
// Pipelined restoring divider for one unit-vector component.
`default_nettype none
module bhg_div_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [bhg_pkg::DIFF_W-1:0]    numer,
   input  wire logic [bhg_pkg::ROOT_W-1:0]    denom,
   output logic [FRAC_BITS:0]                 quot
);

   localparam int N  = FRAC_BITS + 1;
   localparam int DW = bhg_pkg::ROOT_W;

   logic [DW-1:0] rem_src[N];
   logic [DW-1:0] den_src[N];
   logic [N-1:0]  q_src  [N];
   logic [DW-1:0] rem_in [N];
   logic [N-1:0]  q_in   [N];
   logic [DW-1:0] rem_ff [N];
   logic [DW-1:0] den_ff [N];
   logic [N-1:0]  q_ff   [N];

   always_comb begin
      logic [DW:0] sh;
      logic [DW:0] diff;
      rem_src[0] = numer;
      den_src[0] = denom;
      q_src[0]   = '0;
      for (int i = 1; i < N; i++) begin
         rem_src[i] = rem_ff[i-1];
         den_src[i] = den_ff[i-1];
         q_src[i]   = q_ff[i-1];
      end
      for (int i = 0; i < N; i++) begin
         sh   = (i == 0) ? {1'b0, rem_src[i]} : {rem_src[i], 1'b0};
         diff = sh - {1'b0, den_src[i]};
         if (sh >= {1'b0, den_src[i]}) begin
            rem_in[i] = diff[DW-1:0];
            q_in[i]   = {q_src[i][N-2:0], 1'b1};
         end else begin
            rem_in[i] = sh[DW-1:0];
            q_in[i]   = {q_src[i][N-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < N; i++) begin
            rem_ff[i] <= rem_in[i];
            den_ff[i] <= den_src[i];
            q_ff[i]   <= q_in[i];
         end
      end
   end

   assign quot = q_ff[N-1];

endmodule
`default_nettype wire

@@ rtl/bhg_back.sv @@
// Back stages: handle offsets, final sums with saturation, output register.
`default_nettype none
module bhg_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire bhg_pkg::mid_type    mid,
   input  wire logic [FRAC_BITS:0]  ux,
   input  wire logic [FRAC_BITS:0]  uy,
   input  wire logic [FRAC_BITS:0]  vx,
   input  wire logic [FRAC_BITS:0]  vy,
   output bhg_pkg::rsp_type         rsp
);

   localparam int QW = FRAC_BITS + 1;
   localparam int SW = bhg_pkg::ROOT_W;
   localparam int PW = QW + SW;
   localparam int CW = bhg_pkg::COORD_W;
   localparam int MW = bhg_pkg::DIFF_W;

   typedef struct packed {
      logic signed [CW-1:0] a1_x;
      logic signed [CW-1:0] a1_y;
      logic signed [CW-1:0] a2_x;
      logic signed [CW-1:0] a2_y;
      logic [MW-1:0]        t1x_mag;
      logic [MW-1:0]        t1y_mag;
      logic [MW-1:0]        t2x_mag;
      logic [MW-1:0]        t2y_mag;
      logic                 t1x_neg;
      logic                 t1y_neg;
      logic                 t2x_neg;
      logic                 t2y_neg;
      logic                 deg;
   } term_type;

   typedef struct packed {
      logic                 sat;
      logic signed [CW-1:0] value;
   } sat_type;

   function automatic sat_type sat_add(input logic [CW-1:0] a, input logic neg,
                                       input logic [MW-1:0] m);
      logic [CW+2:0] ax;
      logic [CW+2:0] mx;
      logic [CW+2:0] sum;
      sat_type       res;
      ax  = {{3{a[CW-1]}}, a};
      mx  = {2'b00, m};
      sum = neg ? (ax - mx) : (ax + mx);
      res.sat = 1'b1;
      if (!sum[CW+2] && (|sum[CW+1:CW-1])) begin
         res.value = {1'b0, {(CW-1){1'b1}}};
      end else if (sum[CW+2] && !(&sum[CW+1:CW-1])) begin
         res.value = {1'b1, {(CW-1){1'b0}}};
      end else begin
         res.sat   = 1'b0;
         res.value = sum[CW-1:0];
      end
      return res;
   endfunction

   logic          quad;
   logic [QW-1:0] ux_m, uy_m, vx_m, vy_m;
   logic [PW-1:0] pux, puy, pvx, pvy;
   term_type      term_in, term_ff;
   sat_type       h1x, h1y, h2x, h2y;
   bhg_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      quad = (mid.side.op == bhg_pkg::OP_QUAD);
      ux_m = mid.z1 ? '0 : ux;
      uy_m = mid.z1 ? '0 : uy;
      vx_m = mid.z2 ? '0 : vx;
      vy_m = mid.z2 ? '0 : vy;
      pux  = {{SW{1'b0}}, ux_m} * {{QW{1'b0}}, mid.s};
      puy  = {{SW{1'b0}}, uy_m} * {{QW{1'b0}}, mid.s};
      pvx  = {{SW{1'b0}}, vx_m} * {{QW{1'b0}}, mid.s};
      pvy  = {{SW{1'b0}}, vy_m} * {{QW{1'b0}}, mid.s};
      term_in.a1_x    = mid.side.a1_x;
      term_in.a1_y    = mid.side.a1_y;
      term_in.a2_x    = mid.side.a2_x;
      term_in.a2_y    = mid.side.a2_y;
      term_in.t1x_mag = quad ? pux[FRAC_BITS +: MW] : mid.side.off_x_mag;
      term_in.t1y_mag = quad ? puy[FRAC_BITS +: MW] : mid.side.off_y_mag;
      term_in.t1x_neg = quad ? mid.side.d1x_neg : mid.side.off_x_neg;
      term_in.t1y_neg = quad ? mid.side.d1y_neg : mid.side.off_y_neg;
      // second handle is subtracted from its anchor: flip the sign
      term_in.t2x_mag = quad ? pvx[FRAC_BITS +: MW] : pux[FRAC_BITS +: MW];
      term_in.t2y_mag = quad ? pvy[FRAC_BITS +: MW] : puy[FRAC_BITS +: MW];
      term_in.t2x_neg = quad ? !mid.side.d2x_neg : !mid.side.d1x_neg;
      term_in.t2y_neg = quad ? !mid.side.d2y_neg : !mid.side.d1y_neg;
      term_in.deg     = mid.z1 | (quad & mid.z2);
   end

   always_comb begin
      h1x = sat_add(term_ff.a1_x, term_ff.t1x_neg, term_ff.t1x_mag);
      h1y = sat_add(term_ff.a1_y, term_ff.t1y_neg, term_ff.t1y_mag);
      h2x = sat_add(term_ff.a2_x, term_ff.t2x_neg, term_ff.t2x_mag);
      h2y = sat_add(term_ff.a2_y, term_ff.t2y_neg, term_ff.t2y_mag);
      rsp_in.h1_x = h1x.value;
      rsp_in.h1_y = h1y.value;
      rsp_in.h2_x = h2x.value;
      rsp_in.h2_y = h2y.value;
      rsp_in.degenerate = term_ff.deg | h1x.sat | h1y.sat | h2x.sat | h2y.sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= term_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/bezier_handle_generator_top.sv @@
// Top level of the Bezier handle generator.
//
// Input channel req_*: one item carries an opcode and four Q16.16 points.
// Result channel rsp_*: one item per input, two handle points and a flag.
// Both sides use valid/stall; an item moves when valid is high and stall low.
// csr_wr_en/csr_wr_data write the handle ratio (unsigned Q0.16); write it
// only while no item is in flight.
//
// The pipeline has three front stages, 33 square-root stages (one root bit
// each), one scale stage, FRAC_BITS + 1 divider stages (one quotient bit
// each) and two back stages ending in the output register. Throughput is
// one item per cycle while the result side does not stall.
//
// Reset clears every valid bit and loads the ratio with 21845. While the
// result sits in the output register under stall, the whole pipeline holds
// and req_stall is raised; otherwise req_stall is low.
`default_nettype none
module bezier_handle_generator_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire bhg_pkg::req_type                   req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output bhg_pkg::rsp_type                        rsp_data,
   input  wire logic                               csr_wr_en,
   input  wire logic [bhg_pkg::RATIO_BITS-1:0]     csr_wr_data
);

   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int SQ        = bhg_pkg::SQRT_STEPS;
   localparam int LAT       = bhg_pkg::FRONT_STAGES + SQ + 1 + DIV_STEPS
                              + bhg_pkg::BACK_STAGES;
   localparam int RB        = bhg_pkg::RATIO_BITS;
   localparam int LW        = bhg_pkg::ROOT_W;
   localparam int SPW       = LW + RB;

   logic                       en;
   logic [RB-1:0]              ratio_ff;
   logic [LAT-1:0]             vld_in, vld_ff;
   logic [bhg_pkg::RAD_W-1:0]  rad1, rad2, rad3;
   logic [LW-1:0]              len1, len2, len3;
   logic [LW-1:0]              len1_ff, len2_ff;
   logic [SPW-1:0]             s_prod;
   logic [FRAC_BITS:0]         ux, uy, vx, vy;
   bhg_pkg::side_type          front_side;
   bhg_pkg::side_type          side_sq_ff[SQ];
   bhg_pkg::mid_type           mid_in, mid_ff;
   bhg_pkg::mid_type           mid_dv_ff[DIV_STEPS];

   assign req_stall = rsp_valid & rsp_stall;
   assign en        = !req_stall;
   assign rsp_valid = vld_ff[LAT-1];
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= bhg_pkg::RATIO_RESET;
      end else if (csr_wr_en) begin
         ratio_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   bhg_front u_front (
      .clock (clock),
      .en    (en),
      .req   (req_data),
      .ratio (ratio_ff),
      .rad1  (rad1),
      .rad2  (rad2),
      .rad3  (rad3),
      .side  (front_side)
   );

   bhg_sqrt_pipe u_sqrt1 (.clock(clock), .en(en), .radicand(rad1), .root(len1));
   bhg_sqrt_pipe u_sqrt2 (.clock(clock), .en(en), .radicand(rad2), .root(len2));
   bhg_sqrt_pipe u_sqrt3 (.clock(clock), .en(en), .radicand(rad3), .root(len3));

   always_comb begin
      s_prod      = {{RB{1'b0}}, len3} * {{LW{1'b0}}, ratio_ff};
      mid_in.side = side_sq_ff[SQ-1];
      mid_in.s    = s_prod[SPW-1:RB];
      mid_in.z1   = (len1 == '0);
      mid_in.z2   = (len2 == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_sq_ff[0] <= front_side;
         for (int i = 1; i < SQ; i++) begin
            side_sq_ff[i] <= side_sq_ff[i-1];
         end
         mid_ff  <= mid_in;
         len1_ff <= len1;
         len2_ff <= len2;
         mid_dv_ff[0] <= mid_ff;
         for (int i = 1; i < DIV_STEPS; i++) begin
            mid_dv_ff[i] <= mid_dv_ff[i-1];
         end
      end
   end

   bhg_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_ux (
      .clock(clock), .en(en), .numer(mid_ff.side.d1x_mag), .denom(len1_ff), .quot(ux));
   bhg_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_uy (
      .clock(clock), .en(en), .numer(mid_ff.side.d1y_mag), .denom(len1_ff), .quot(uy));
   bhg_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_vx (
      .clock(clock), .en(en), .numer(mid_ff.side.d2x_mag), .denom(len2_ff), .quot(vx));
   bhg_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_vy (
      .clock(clock), .en(en), .numer(mid_ff.side.d2y_mag), .denom(len2_ff), .quot(vy));

   bhg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock (clock),
      .en    (en),
      .mid   (mid_dv_ff[DIV_STEPS-1]),
      .ux    (ux),
      .uy    (uy),
      .vx    (vx),
      .vy    (vy),
      .rsp   (rsp_data)
   );

endmodule
`default_nettype wire

@@ rtl/bhg_check.sv @@
// Port checker for the Bezier handle generator, bound to the top level.
`default_nettype none
module bhg_check (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire bhg_pkg::rsp_type  rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled while the result side is free");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result item");

endmodule

bind bezier_handle_generator_top bhg_check u_bhg_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

@@ tb/sv/bezier_handle_generator_top_tb.sv @@
// Self-checking testbench for the Bezier handle generator top level.
`default_nettype none
module bezier_handle_generator_top_tb;

   localparam int LATENCY = 56;

   typedef logic [135:0] wide_type;

   typedef struct {
      bhg_pkg::req_type  item;
      bit                typed;
      bhg_pkg::rsp_type  answer;
   } seed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   bhg_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   bhg_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic [15:0]      csr_wr_data = '0;

   logic [15:0]      ratio_now = bhg_pkg::RATIO_RESET;
   bhg_pkg::rsp_type handle_q[$];
   int               failures = 0;
   bit               gaps_on = 1'b1;
   bit               long_hold = 1'b0;
   seed_row_type     seed_rows[$];

   bezier_handle_generator_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint signed_as(longint src, logic [63:0] m);
      return src < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [63:0] seg_length(longint dx, longint dy);
      wide_type     n, c;
      logic [63:0]  r;
      r = '0;
      n = wide_type'(mag(dx)) * wide_type'(mag(dx))
          + wide_type'(mag(dy)) * wide_type'(mag(dy));
      for (int b = 34; b >= 0; b--) begin
         c = wide_type'(r | (64'd1 << b));
         if (c * c <= n) r = c[63:0];
      end
      return r;
   endfunction

   function automatic longint unit_part(longint d, logic [63:0] len);
      if (len == 0) return 0;
      return signed_as(d, (mag(d) << 16) / len);
   endfunction

   function automatic longint scale_part(longint v, logic [63:0] m, int sh);
      return signed_as(v, (mag(v) * m) >> sh);
   endfunction

   function automatic logic [31:0] clamp32(longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'h7fffffff;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic bhg_pkg::rsp_type predict_handles(bhg_pkg::req_type r,
                                                        logic [15:0] k);
      longint            p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
      longint            ux, uy, vx, vy, dx, dy, h1x, h1y, h2x, h2y;
      logic [63:0]       len, s, kk;
      bit                deg;
      bhg_pkg::rsp_type  o;
      p1x = r.p1_x; p1y = r.p1_y; p2x = r.p2_x; p2y = r.p2_y;
      p3x = r.p3_x; p3y = r.p3_y; p4x = r.p4_x; p4y = r.p4_y;
      kk = {48'd0, k};
      deg = 1'b0;
      len = seg_length(p3x - p1x, p3y - p1y);
      if (len == 0) deg = 1'b1;
      ux = unit_part(p3x - p1x, len);
      uy = unit_part(p3y - p1y, len);
      if (r.opcode == bhg_pkg::OP_QUAD) begin
         len = seg_length(p4x - p2x, p4y - p2y);
         if (len == 0) deg = 1'b1;
         vx = unit_part(p4x - p2x, len);
         vy = unit_part(p4y - p2y, len);
         s = (seg_length(p3x - p2x, p3y - p2y) * kk) >> 16;
         h1x = p2x + scale_part(ux, s, 16);
         h1y = p2y + scale_part(uy, s, 16);
         h2x = p3x - scale_part(vx, s, 16);
         h2y = p3y - scale_part(vy, s, 16);
      end else begin
         dx = p2x - p1x;
         dy = p2y - p1y;
         h1x = p1x + scale_part(dx, kk, 16);
         h1y = p1y + scale_part(dy, kk, 16);
         s = (seg_length(dx, dy) * kk) >> 16;
         h2x = p2x - scale_part(ux, s, 16);
         h2y = p2y - scale_part(uy, s, 16);
      end
      o.h1_x = clamp32(h1x, deg);
      o.h1_y = clamp32(h1y, deg);
      o.h2_x = clamp32(h2x, deg);
      o.h2_y = clamp32(h2y, deg);
      o.degenerate = deg;
      return o;
   endfunction

   function automatic bhg_pkg::req_type make_item(bhg_pkg::op_type op, int a, int b,
                                                  int c, int d, int e, int f,
                                                  int g, int h);
      bhg_pkg::req_type r;
      r.opcode = op;
      r.p1_x = a; r.p1_y = b; r.p2_x = c; r.p2_y = d;
      r.p3_x = e; r.p3_y = f; r.p4_x = g; r.p4_y = h;
      return r;
   endfunction

   function automatic int pick_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         2: return $urandom_range(0, 255) + 32'h7fff_ff00;
         default: return $urandom_range(0, 255) + 32'h8000_0000;
      endcase
   endfunction

   function automatic bhg_pkg::req_type random_item();
      bhg_pkg::req_type  r;
      int                mode, shape;
      mode = $urandom_range(0, 9);
      mode = mode < 5 ? 1 : (mode < 8 ? 0 : $urandom_range(2, 3));
      r.opcode = bhg_pkg::op_type'($urandom_range(0, 1));
      r.p1_x = pick_coord(mode); r.p1_y = pick_coord(mode);
      r.p2_x = pick_coord(mode); r.p2_y = pick_coord(mode);
      r.p3_x = pick_coord(mode); r.p3_y = pick_coord(mode);
      r.p4_x = pick_coord(mode); r.p4_y = pick_coord(mode);
      shape = $urandom_range(0, 15);
      if (shape == 0) begin
         r.p3_x = r.p1_x; r.p3_y = r.p1_y;
      end else if (shape == 1) begin
         r.p4_x = r.p2_x; r.p4_y = r.p2_y;
      end else if (shape == 2) begin
         r.p3_x = r.p2_x; r.p3_y = r.p2_y;
      end else if (shape == 3) begin
         r.p2_x = r.p1_x; r.p2_y = r.p1_y;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         handle_q.push_back(predict_handles(req_data, ratio_now));
   end

   always @(posedge clock) begin
      bhg_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (handle_q.size() == 0) begin
            $display("%0t: unexpected item %h", $time, rsp_data);
            failures++;
         end else begin
            e = handle_q.pop_front();
            if (e.h1_x !== rsp_data.h1_x || e.h1_y !== rsp_data.h1_y ||
                e.h2_x !== rsp_data.h2_x || e.h2_y !== rsp_data.h2_y ||
                e.degenerate !== rsp_data.degenerate) begin
               $display("%0t: handle mismatch expected h1=(%h,%h) h2=(%h,%h) deg=%b",
                        $time, e.h1_x, e.h1_y, e.h2_x, e.h2_y, e.degenerate);
               $display("%0t:                 actual   h1=(%h,%h) h2=(%h,%h) deg=%b",
                        $time, rsp_data.h1_x, rsp_data.h1_y, rsp_data.h2_x,
                        rsp_data.h2_y, rsp_data.degenerate);
               failures++;
            end
         end
      end
   end

   initial begin
      int hold_left;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            for (hold_left = 400; hold_left > 0; hold_left--) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
            @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   task automatic send_item(bhg_pkg::req_type r);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (handle_q.size() == 0);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_ratio(logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ratio_now = v;
      @(posedge clock);
   endtask

   task automatic add_seed(bhg_pkg::req_type r, bit typed, bhg_pkg::rsp_type a);
      seed_row_type row;
      row.item = r;
      row.typed = typed;
      row.answer = a;
      seed_rows.push_back(row);
   endtask

   initial begin
      bhg_pkg::rsp_type  same_pt;
      logic [15:0]       ratios[6];
      int                max_p, min_p;
      max_p = 32'h7fffffff;
      min_p = 32'h80000000;
      same_pt = '{h1_x: 32'h0001_0000, h1_y: 32'hffff_0000,
                  h2_x: 32'h0001_0000, h2_y: 32'hffff_0000, degenerate: 1'b1};
      add_seed(make_item(bhg_pkg::OP_QUAD, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
               '{default: 0, degenerate: 1});
      add_seed(make_item(bhg_pkg::OP_TRIPLE, 0, 0, 0, 0, 0, 0, -1, -1), 1'b1,
               '{default: 0, degenerate: 1});
      add_seed(make_item(bhg_pkg::OP_QUAD, 32'h10000, 32'hffff0000, 32'h10000,
                         32'hffff0000, 32'h10000, 32'hffff0000, 32'h10000,
                         32'hffff0000), 1'b1, same_pt);
      add_seed(make_item(bhg_pkg::OP_QUAD, min_p, min_p, min_p, min_p, max_p, max_p,
                         max_p, max_p), 1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_QUAD, max_p, max_p, max_p, min_p, min_p, max_p,
                         min_p, min_p), 1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_TRIPLE, min_p, min_p, max_p, max_p, max_p, max_p,
                         0, 0), 1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_TRIPLE, max_p, min_p, min_p, max_p, min_p, max_p,
                         5, 5), 1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_QUAD, 0, 0, 0, 0, 32'h30000, 32'h40000, 32'h60000,
                         32'h80000), 1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_QUAD, -1, -1, 0, 0, 0, 0, 1, 1), 1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_QUAD, 0, 0, 32'h10000, 0, 32'h10000, 0,
                         32'h20000, 0), 1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_TRIPLE, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0),
               1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_TRIPLE, 0, 0, 0, 0, 32'h50000, -32'h20000, 0, 0),
               1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_QUAD, max_p, 0, 0, 0, min_p, 0, max_p, max_p),
               1'b0, '0);
      add_seed(make_item(bhg_pkg::OP_TRIPLE, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1,
               '{h1_x: -1, h1_y: -1, h2_x: -1, h2_y: -1, degenerate: 1'b1});

      ratios[0] = bhg_pkg::RATIO_RESET;
      ratios[1] = 16'd0;
      ratios[2] = 16'hffff;
      ratios[3] = 16'($urandom);
      ratios[4] = 16'($urandom);
      ratios[5] = 16'h8000;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (seed_rows[i]) begin
         send_item(seed_rows[i].item);
         if (seed_rows[i].typed && predict_handles(seed_rows[i].item, ratio_now)
             !== seed_rows[i].answer) begin
            $display("%0t: seed row %0d expected %h actual %h", $time, i,
                     seed_rows[i].answer, predict_handles(seed_rows[i].item, ratio_now));
            failures++;
         end
      end
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_ratio(ratios[ph]);
            foreach (seed_rows[i]) send_item(seed_rows[i].item);
         end
         gaps_on = (ph != 3 && ph != 5);
         for (int n = 0; n < 230; n++) begin
            if (ph == 2 && n == 20) long_hold = 1'b1;
            send_item(random_item());
         end
         drain();
      end

      if (failures == 0)
         $display("bezier_handle_generator_top verification clean");
      else
         $display("bezier_handle_generator_top verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("bezier_handle_generator_top verification failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/bhg_pkg.sv
rtl/bhg_front.sv
rtl/bhg_sqrt_pipe.sv
rtl/bhg_div_pipe.sv
rtl/bhg_back.sv
rtl/bezier_handle_generator_top.sv
rtl/bhg_check.sv
tb/sv/bezier_handle_generator_top_tb.sv
